// ===== src/tbpf_pkg.sv =====
// ============================================================================
// Tile background pixel fetch - shared definitions
// Types, register indexes and address constants used across the front end,
// the item queue and the back end.
// ============================================================================
package tbpf_pkg;

   // Screen and memory geometry
   localparam int SCREEN_WIDTH  = 160;
   localparam int VISIBLE_LINES = 144;
   localparam int VRAM_BYTES    = 8192;
   localparam int VRAM_AW       = $clog2(VRAM_BYTES);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PW      = $clog2(QUEUE_DEPTH);

   // Offsets inside video memory (memory base is 0x8000)
   localparam logic [VRAM_AW-1:0] MAP_LOW_OFS     = 13'h1800;
   localparam logic [VRAM_AW-1:0] MAP_HIGH_OFS    = 13'h1C00;
   localparam logic [VRAM_AW-1:0] SIGNED_DATA_OFS = 13'h0800;

   // The window position register holds the start column plus this amount
   localparam logic [7:0] WIN_X_BIAS = 8'd7;

   // Display control bits
   localparam int CTRL_WIN_MAP  = 6;
   localparam int CTRL_WIN_EN   = 5;
   localparam int CTRL_TILE_SEL = 4;
   localparam int CTRL_BG_MAP   = 3;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      CSR_DISPLAY_CONTROL = 3'd0,
      CSR_SCROLL_X        = 3'd1,
      CSR_SCROLL_Y        = 3'd2,
      CSR_WINDOW_X_RAW    = 3'd3,
      CSR_WINDOW_Y        = 3'd4
   } csr_index_type;

   // Item operation codes
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   // Context that travels with a render item through the back end
   typedef struct packed {
      logic [2:0] fine_x;
      logic [2:0] fine_y;
      logic [7:0] px;
      logic [7:0] ln;
   } pix_type;

   // One classified item in the queue: a memory write or a map fetch
   typedef struct packed {
      logic               is_write;
      logic [VRAM_AW-1:0] addr;
      logic [7:0]         wdata;
      pix_type            pix;
   } entry_type;

endpackage

// ===== src/tbpf_front.sv =====
// ============================================================================
// Tile background pixel fetch - front end
// Holds the configuration registers, accepts items, drops renders that fall
// off screen, and turns each render into a tile-map address plus context.
// ============================================================================
module tbpf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [12:0]           req_vram_addr,
   input  logic [7:0]            req_vram_data,
   input  logic [7:0]            req_pixel_x,
   input  logic [7:0]            req_screen_line,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  clearing,
   input  logic                  queue_full,
   output logic                  push,
   output tbpf_pkg::entry_type   push_entry,
   output logic                  tile_unsigned
);
   import tbpf_pkg::*;

   logic [7:0] ctrl_ff, ctrl_in;
   logic [7:0] scx_ff, scx_in;
   logic [7:0] scy_ff, scy_in;
   logic [7:0] wxr_ff, wxr_in;
   logic [7:0] wy_ff, wy_in;

   logic       accept;
   logic       on_screen;
   logic [7:0] win_col;
   logic       in_window;
   logic [7:0] map_x;
   logic [7:0] map_y;
   logic       map_sel;

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      ctrl_in = ctrl_ff;
      scx_in  = scx_ff;
      scy_in  = scy_ff;
      wxr_in  = wxr_ff;
      wy_in   = wy_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DISPLAY_CONTROL: ctrl_in = csr_wdata;
            CSR_SCROLL_X:        scx_in  = csr_wdata;
            CSR_SCROLL_Y:        scy_in  = csr_wdata;
            CSR_WINDOW_X_RAW:    wxr_in  = csr_wdata;
            CSR_WINDOW_Y:        wy_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         scx_ff  <= '0;
         scy_ff  <= '0;
         wxr_ff  <= '0;
         wy_ff   <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
         scx_ff  <= scx_in;
         scy_ff  <= scy_in;
         wxr_ff  <= wxr_in;
         wy_ff   <= wy_in;
      end
   end

   assign tile_unsigned = ctrl_ff[CTRL_TILE_SEL];

   // Handshake: hold off while memory is being cleared or the queue is full.
   assign busy   = clearing | queue_full;
   assign accept = start & ~busy;

   // Window or background decision and the wrapped map coordinates.
   assign on_screen = ({1'b0, req_pixel_x} < 9'(SCREEN_WIDTH)) &&
                      ({1'b0, req_screen_line} < 9'(VISIBLE_LINES));
   assign win_col   = wxr_ff - WIN_X_BIAS;
   assign in_window = ctrl_ff[CTRL_WIN_EN] && (req_screen_line >= wy_ff) &&
                      (req_pixel_x >= win_col);

   always_comb begin
      if (in_window) begin
         map_x   = req_pixel_x - win_col;
         map_y   = req_screen_line - wy_ff;
         map_sel = ctrl_ff[CTRL_WIN_MAP];
      end else begin
         map_x   = req_pixel_x + scx_ff;
         map_y   = req_screen_line + scy_ff;
         map_sel = ctrl_ff[CTRL_BG_MAP];
      end
   end

   // Build the queue entry; off-screen renders never enter the queue.
   always_comb begin
      push_entry.is_write   = (req_op == OP_WRITE);
      push_entry.wdata      = req_vram_data;
      push_entry.pix.fine_x = map_x[2:0];
      push_entry.pix.fine_y = map_y[2:0];
      push_entry.pix.px     = req_pixel_x;
      push_entry.pix.ln     = req_screen_line;
      if (req_op == OP_WRITE) begin
         push_entry.addr = req_vram_addr;
      end else begin
         push_entry.addr = (map_sel ? MAP_HIGH_OFS : MAP_LOW_OFS) |
                           {3'b000, map_y[7:3], map_x[7:3]};
      end
   end

   assign push = accept & ((req_op == OP_WRITE) | on_screen);

endmodule

// ===== src/tbpf_queue.sv =====
// ============================================================================
// Tile background pixel fetch - item queue
// A short FIFO of classified items between the front end and the back end.
// ============================================================================
module tbpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tbpf_pkg::entry_type   push_entry,
   input  logic                  pop,
   output logic                  head_valid,
   output tbpf_pkg::entry_type   head_entry,
   output logic                  full
);
   import tbpf_pkg::*;

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PW:0]       count_ff, count_in;
   logic                    do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QUEUE_PW+1)'(QUEUE_DEPTH));
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the front end only pushes when the queue is not full.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/tbpf_back.sv =====
// ============================================================================
// Tile background pixel fetch - back end
// Owns the video memory. Clears it after reset, then carries out queued
// items: writes directly, renders as a map read followed by a read of
// both plane bytes, and finally picks the pixel's two color bits.
// ============================================================================
module tbpf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  tbpf_pkg::entry_type   head_entry,
   input  logic                  tile_unsigned,
   output logic                  pop,
   output logic                  clearing,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_pixel_color,
   output logic [7:0]            rsp_out_x,
   output logic [7:0]            rsp_out_line
);
   import tbpf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_MAP   = 3'b010,
      ST_ROW   = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [VRAM_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   pix_type              ctx_ff, ctx_in;
   pix_type              col_ctx_ff;
   logic                 col_valid_ff, col_valid_in;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_color_ff, rsp_color_in;
   logic [7:0]           rsp_x_ff;
   logic [7:0]           rsp_line_ff;

   logic [7:0]           vram_ff [VRAM_BYTES];
   logic [7:0]           rd_a_ff;
   logic [7:0]           rd_b_ff;
   logic                 mem_we;
   logic [VRAM_AW-1:0]   mem_waddr;
   logic [7:0]           mem_wdata;
   logic [VRAM_AW-1:0]   rd_a_addr;
   logic [VRAM_AW-1:0]   rd_b_addr;
   logic [VRAM_AW-1:0]   tile_base;
   logic [VRAM_AW-1:0]   row_addr;
   logic [7:0]           tile_num;

   assign clearing = (state_ff == ST_CLEAR);

   // Tile row address from the map byte read in the previous cycle.
   assign tile_num  = rd_a_ff;
   assign tile_base = tile_unsigned ? {1'b0, tile_num, 4'h0} :
                      SIGNED_DATA_OFS + {1'b0, tile_num ^ 8'h80, 4'h0};
   assign row_addr  = tile_base | {{(VRAM_AW-4){1'b0}}, ctx_ff.fine_y, 1'b0};
   assign rd_b_addr = {row_addr[VRAM_AW-1:1], 1'b1};

   // Sequencer: clearing sweep, then map fetch and row fetch per render.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      ctx_in       = ctx_ff;
      col_valid_in = 1'b0;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = head_entry.addr;
      mem_wdata    = head_entry.wdata;
      rd_a_addr    = head_entry.addr;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head_entry.is_write) begin
                  mem_we = 1'b1;
               end else begin
                  ctx_in   = head_entry.pix;
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            rd_a_addr    = row_addr;
            col_valid_in = 1'b1;
            state_in     = ST_MAP;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         col_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         col_valid_ff <= col_valid_in;
         rsp_valid_ff <= col_valid_ff;
      end
   end

   // Render context, one copy per back-end stage.
   always_ff @(posedge clock) begin
      ctx_ff <= ctx_in;
      if (col_valid_in) begin
         col_ctx_ff <= ctx_ff;
      end
   end

   // Video memory: one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= vram_ff[rd_a_addr];
      rd_b_ff <= vram_ff[rd_b_addr];
   end

   // Color stage: bit 7 of each plane byte is the leftmost pixel.
   assign rsp_color_in = {rd_b_ff[~col_ctx_ff.fine_x], rd_a_ff[~col_ctx_ff.fine_x]};

   always_ff @(posedge clock) begin
      if (col_valid_ff) begin
         rsp_color_ff <= rsp_color_in;
         rsp_x_ff     <= col_ctx_ff.px;
         rsp_line_ff  <= col_ctx_ff.ln;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_line    = rsp_line_ff;

endmodule

// ===== src/tile_background_pixel_fetch.sv =====
// ============================================================================
// Tile background pixel fetch - top level
// Video memory with background and window pixel lookup behind a start/busy
// command port and a single-cycle result strobe.
// ============================================================================
// After reset the block holds busy high while it clears the video memory
// one byte per cycle; configuration writes are taken at any time. Items are
// then accepted in back-to-back cycles until the four-entry queue fills.
// The back end retires a memory write as soon as it pops it and a render in
// two steps, the tile-map read and then the read of both plane bytes on the
// two memory read ports, and takes no new item during a render's second step.
// A render's result appears on the rsp_ ports after the queue slot, map read,
// plane-byte read and color register, later when items are queued ahead of
// it. rsp_valid is high for exactly one cycle per result and cannot be
// stalled. Renders outside the visible screen and all writes give no result.
module tile_background_pixel_fetch (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [12:0] req_vram_addr,
   input  logic [7:0]  req_vram_data,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_screen_line,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_pixel_color,
   output logic [7:0]  rsp_out_x,
   output logic [7:0]  rsp_out_line
);
   import tbpf_pkg::*;

   logic      clearing;
   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      tile_unsigned;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // Front end: configuration, acceptance and classification.
   tbpf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_vram_addr   (req_vram_addr),
      .req_vram_data   (req_vram_data),
      .req_pixel_x     (req_pixel_x),
      .req_screen_line (req_screen_line),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .clearing        (clearing),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry),
      .tile_unsigned   (tile_unsigned)
   );

   // Queue between the two halves.
   tbpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   // Back end: memory access and color selection.
   tbpf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .tile_unsigned   (tile_unsigned),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_line    (rsp_out_line)
   );

endmodule

// ===== src/tbpf_checker.sv =====
// ============================================================================
// Tile background pixel fetch - port checker
// Watches the top-level ports for reset behavior, result spacing and the
// range of reported pixel positions.
// ============================================================================
module tbpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_out_x,
   input logic [7:0]  rsp_out_line
);
   import tbpf_pkg::*;

   // The memory clearing sweep keeps the block busy right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy not raised after reset");

   // No result is reported in the cycle after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // A render holds the map and row states, so results never come back to back.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in consecutive cycles");

   // Only on-screen pixels produce results.
   a_rsp_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_out_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, rsp_out_line} < 9'(VISIBLE_LINES))))
      else $error("result for an off-screen pixel");

   // A start during busy must not be lost silently by the block accepting it:
   // busy that was set by reset stays set for the next cycle too.
   a_busy_holds: assert property (@(posedge clock)
      (reset && start) |=> busy)
      else $error("item accepted during reset clearing");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Tile background pixel fetch - self-checking testbench
// Fills video memory with write items and renders pixels through the start/
// busy port. Each on-screen render takes its color from a behavioral lookup
// held here or from its table row, and every strobed result is compared field
// by field with the oldest pending pixel. A short directed table comes first,
// then random phases under changing scroll, window and tile address settings.
// ============================================================================
module tb_top;
   import tbpf_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 16;
   localparam int NUM_PHASES    = 13;
   localparam int PHASE_ITEMS   = 150;
   localparam int MAX_GAP       = 13;
   localparam int RUN_LIMIT_NS  = 2_000_000;
   localparam int REPORT_LINES  = 40;

   // Register indexes past the last defined register; writes there do nothing
   localparam logic [2:0] CSR_SPARE_LO = 3'(CSR_WINDOW_Y) + 3'd1;
   localparam logic [2:0] CSR_SPARE_HI = '1;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One line of the directed table; a register write keeps its index in addr
   typedef struct packed {
      row_kind_type kind;
      op_type       op;
      logic [12:0]  addr;
      logic [7:0]   data;
      logic [7:0]   px;
      logic [7:0]   ln;
      logic         typed;
      logic [1:0]   color;
   } stim_row_type;

   typedef struct packed {
      logic [1:0] color;
      logic [7:0] px;
      logic [7:0] ln;
   } pixel_expect_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [12:0] req_vram_addr;
   logic [7:0]  req_vram_data;
   logic [7:0]  req_pixel_x;
   logic [7:0]  req_screen_line;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        rsp_valid;
   logic [1:0]  rsp_pixel_color;
   logic [7:0]  rsp_out_x;
   logic [7:0]  rsp_out_line;

   // Shadow of the block's memory and registers
   logic [7:0] vram_model [0:VRAM_BYTES-1];
   logic [7:0] ctrl_q;
   logic [7:0] scroll_x_q;
   logic [7:0] scroll_y_q;
   logic [7:0] win_x_raw_q;
   logic [7:0] win_y_q;

   pixel_expect_type pending_pixels [$];
   stim_row_type     directed_rows [$];
   int               mismatch_count = 0;

   tile_background_pixel_fetch u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_vram_addr   (req_vram_addr),
      .req_vram_data   (req_vram_data),
      .req_pixel_x     (req_pixel_x),
      .req_screen_line (req_screen_line),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_line    (rsp_out_line)
   );

   always #1 clock = ~clock;

   // The run ends here if the block stops answering.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   // Color of one on-screen pixel under the current registers and memory.
   function automatic logic [1:0] predict_color(input logic [7:0] px,
                                                input logic [7:0] ln);
      logic [7:0]  win_start;
      logic [7:0]  xs;
      logic [7:0]  ys;
      logic [12:0] map_base;
      logic [7:0]  tile_id;
      logic [12:0] row_addr;
      logic [2:0]  bit_sel;
      win_start = win_x_raw_q - WIN_X_BIAS;
      if (ctrl_q[CTRL_WIN_EN] && ln >= win_y_q && px >= win_start) begin
         map_base = ctrl_q[CTRL_WIN_MAP] ? MAP_HIGH_OFS : MAP_LOW_OFS;
         xs = px - win_start;
         ys = ln - win_y_q;
      end else begin
         map_base = ctrl_q[CTRL_BG_MAP] ? MAP_HIGH_OFS : MAP_LOW_OFS;
         xs = px + scroll_x_q;
         ys = ln + scroll_y_q;
      end
      tile_id = vram_model[map_base + 13'({ys[7:3], xs[7:3]})];
      // Unsigned tiles sit at the base; signed ones are centered on 0x9000
      if (ctrl_q[CTRL_TILE_SEL]) begin
         row_addr = {1'b0, tile_id, 4'b0000};
      end else begin
         row_addr = SIGNED_DATA_OFS + {1'b0, tile_id ^ 8'h80, 4'b0000};
      end
      row_addr = row_addr + 13'({ys[2:0], 1'b0});
      bit_sel  = 3'd7 - xs[2:0];
      return {vram_model[row_addr + 13'd1][bit_sel], vram_model[row_addr][bit_sel]};
   endfunction

   // Register write while the block is idle; the shadow follows the port.
   task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DISPLAY_CONTROL: ctrl_q      = value;
         CSR_SCROLL_X:        scroll_x_q  = value;
         CSR_SCROLL_Y:        scroll_y_q  = value;
         CSR_WINDOW_X_RAW:    win_x_raw_q = value;
         CSR_WINDOW_Y:        win_y_q     = value;
         default: ;
      endcase
   endtask

   // Present one item and hold it until the block takes it.
   task automatic send_item(input op_type op, input logic [12:0] addr,
                            input logic [7:0] data, input logic [7:0] px,
                            input logic [7:0] ln, input logic typed,
                            input logic [1:0] typed_color);
      pixel_expect_type want;
      @(negedge clock);
      start           <= 1'b1;
      req_op          <= op;
      req_vram_addr   <= addr;
      req_vram_data   <= data;
      req_pixel_x     <= px;
      req_screen_line <= ln;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      if (op == OP_WRITE) begin
         vram_model[addr] = data;
      end else if (px < SCREEN_WIDTH && ln < VISIBLE_LINES) begin
         want.color = typed ? typed_color : predict_color(px, ln);
         want.px    = px;
         want.ln    = ln;
         pending_pixels.push_back(want);
      end
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Stop sending, wait for every pending pixel, then let the queue settle.
   task automatic drain_pixels();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register values lean toward both ends of the byte.
   function automatic logic [7:0] edge_biased_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Every strobed result must match the oldest pending pixel.
   always @(posedge clock) begin
      pixel_expect_type want;
      if (!reset && $isunknown(rsp_valid)) begin
         flag_mismatch("result strobe is unknown");
      end else if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel x=%0d line=%0d",
                                    rsp_out_x, rsp_out_line));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_color !== want.color) begin
               flag_mismatch($sformatf("pixel (%0d,%0d) color %0d, wanted %0d",
                                       want.px, want.ln, rsp_pixel_color, want.color));
            end
            if (rsp_out_x !== want.px) begin
               flag_mismatch($sformatf("out_x %0d, wanted %0d", rsp_out_x, want.px));
            end
            if (rsp_out_line !== want.ln) begin
               flag_mismatch($sformatf("out_line %0d, wanted %0d",
                                       rsp_out_line, want.ln));
            end
         end
      end
   end

   // Stimulus: directed table, then random phases between register updates.
   initial begin
      stim_row_type row;
      logic [7:0]   px;
      logic [7:0]   ln;
      logic [7:0]   win_start;
      logic [12:0]  addr;
      int           pick;
      int           counted;
      bit           burst;

      reset           = 1'b1;
      start           = 1'b0;
      req_op          = OP_WRITE;
      req_vram_addr   = '0;
      req_vram_data   = '0;
      req_pixel_x     = '0;
      req_screen_line = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      for (int i = 0; i < VRAM_BYTES; i++) vram_model[i] = '0;
      ctrl_q      = '0;
      scroll_x_q  = '0;
      scroll_y_q  = '0;
      win_x_raw_q = '0;
      win_y_q     = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Reset state, screen corners and off-screen renders, then tile setup
      // for both addressing modes, window placement and unused registers.
      directed_rows = '{
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0,   1'b1, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd159, 8'd143, 1'b1, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd160, 8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd144, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h1FFF, 8'hFF, 8'd255, 8'd255, 1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h1800, 8'h01, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h0010, 8'h80, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h0011, 8'hFF, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h1010, 8'hAA, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h1011, 8'h55, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_DISPLAY_CONTROL), 8'h10, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd1,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h1C00, 8'hFF, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h1FFF, 8'h5A, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_WRITE,  13'h0FF0, 8'hC3, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_DISPLAY_CONTROL), 8'hFF, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_SCROLL_X),        8'hFF, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_SCROLL_Y),        8'hFF, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_WINDOW_X_RAW),    8'd7,  8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_WINDOW_Y),        8'd0,  8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd159, 8'd143, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_WINDOW_X_RAW),    8'd0,  8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd80,  8'd72,  1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_WINDOW_X_RAW),    8'd87, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_WINDOW_Y),        8'd72, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd79,  8'd72,  1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd80,  8'd72,  1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd80,  8'd71,  1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_SPARE_HI),        8'h00, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_SPARE_LO),        8'hFF, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd3,   8'd3,   1'b0, 2'd0},
         '{ROW_CSR,  OP_WRITE,  13'(CSR_DISPLAY_CONTROL), 8'h08, 8'd0, 8'd0, 1'b0, 2'd0},
         '{ROW_ITEM, OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 2'd0}
      };

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            drain_pixels();
            write_register(row.addr[2:0], row.data);
         end else begin
            send_item(row.op, row.addr, row.data, row.px, row.ln, row.typed, row.color);
            idle_sender($urandom_range(0, MAX_GAP));
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // New settings only once the block has gone quiet
         drain_pixels();
         for (int r = 0; r <= int'(CSR_WINDOW_Y); r++) begin
            write_register(3'(r), edge_biased_byte());
         end
         if ($urandom_range(0, 2) == 0) begin
            write_register(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), 8'($urandom));
         end
         burst   = ($urandom_range(0, 3) == 0);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            px   = 8'($urandom);
            ln   = 8'($urandom);
            addr = 13'($urandom);
            if (pick < 35) begin
               // Memory write, a third of them into the tile maps
               if ($urandom_range(0, 2) == 0) begin
                  addr = MAP_LOW_OFS + 13'($urandom_range(0, 2047));
               end
               send_item(OP_WRITE, addr, 8'($urandom), px, ln, 1'b0, 2'd0);
               counted++;
            end else if (pick < 42) begin
               // Off-screen render, ignored by the block
               if ($urandom_range(0, 1) == 0) begin
                  px = 8'($urandom_range(SCREEN_WIDTH, 255));
               end else begin
                  ln = 8'($urandom_range(VISIBLE_LINES, 255));
               end
               send_item(OP_RENDER, addr, 8'($urandom), px, ln, 1'b0, 2'd0);
               counted++;
            end else begin
               // On-screen render, often right at the window's edges
               win_start = win_x_raw_q - WIN_X_BIAS;
               px = 8'($urandom_range(0, SCREEN_WIDTH - 1));
               ln = 8'($urandom_range(0, VISIBLE_LINES - 1));
               if ($urandom_range(0, 3) == 0) begin
                  px = win_start + 8'($urandom_range(0, 2)) - 8'd1;
                  if (px >= SCREEN_WIDTH) px = 8'($urandom_range(0, SCREEN_WIDTH - 1));
               end
               if ($urandom_range(0, 3) == 0) begin
                  ln = win_y_q + 8'($urandom_range(0, 2)) - 8'd1;
                  if (ln >= VISIBLE_LINES) ln = 8'($urandom_range(0, VISIBLE_LINES - 1));
               end
               send_item(OP_RENDER, addr, 8'($urandom), px, ln, 1'b0, 2'd0);
               counted++;
            end
            // Sender hold-off: sometimes until every pending pixel is back, else a random idle gap
            if (counted == PHASE_ITEMS / 2 || $urandom_range(0, 79) == 0) begin
               drain_pixels();
            end else begin
               idle_sender(burst ? 0 : $urandom_range(0, MAX_GAP));
            end
         end
      end

      drain_pixels();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
